[hdl/mckd_pkg.sv]
// Package for the multi-click key detector: key modes, register indexes,
// configuration and lane report types, and the fixed field sizes.
// No dependencies.
package mckd_pkg;

    // Defaults for the module parameters.
    localparam int NUM_KEYS_DEFAULT    = 4;
    localparam int CLICK_WIDTH_DEFAULT = 4;

    // Fixed sizes of the item fields.
    localparam int IN_KEYS         = 4;
    localparam int OUT_KEYS        = 4;
    localparam int OUT_CLICK_WIDTH = 4;
    localparam int TICK_WIDTH      = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLICK_WINDOW = 2'd2;

    // Register reset values.
    localparam logic [TICK_WIDTH-1:0] DEBOUNCE_RESET     = 8'd2;
    localparam logic [TICK_WIDTH-1:0] LONG_PRESS_RESET   = 8'd50;
    localparam logic [TICK_WIDTH-1:0] CLICK_WINDOW_RESET = 8'd30;

    // Per-key mode.
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_HELD     = 2'd2,
        MODE_GAP      = 2'd3
    } key_mode_t;

    // Thresholds shared by all lanes.
    typedef struct packed {
        logic [TICK_WIDTH-1:0] debounce;
        logic [TICK_WIDTH-1:0] long_press;
        logic [TICK_WIDTH-1:0] click_window;
    } cfg_t;

    // What one lane reports for the current item.
    typedef struct packed {
        logic [OUT_CLICK_WIDTH-1:0] clicks;
        logic                       long_press;
    } lane_report_t;

    // Saturating increment of a tick counter.
    function automatic logic [TICK_WIDTH-1:0] sat_inc(input logic [TICK_WIDTH-1:0] v);
        sat_inc = (v == {TICK_WIDTH{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

[hdl/mckd_lane.sv]
// One key lane: debounce, held, click-gap state machine with its counters.
// Depends on mckd_pkg.
module mckd_lane #(
    parameter int CLICK_WIDTH = mckd_pkg::CLICK_WIDTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  pressed,
    input  mckd_pkg::cfg_t        cfg,
    output mckd_pkg::lane_report_t report_next
);

    mckd_pkg::key_mode_t                    mode_reg, mode_next;
    logic [mckd_pkg::TICK_WIDTH-1:0]        hold_reg, hold_next;
    logic [mckd_pkg::TICK_WIDTH-1:0]        gap_reg, gap_next;
    logic [CLICK_WIDTH-1:0]                 click_reg, click_next;
    logic                                   long_reg, long_next;
    logic [mckd_pkg::TICK_WIDTH-1:0]        hold_inc, gap_inc;
    logic [CLICK_WIDTH-1:0]                 click_inc;

    // State registers, updated once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= mckd_pkg::MODE_IDLE;
            hold_reg  <= '0;
            gap_reg   <= '0;
            click_reg <= '0;
            long_reg  <= 1'b0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            hold_reg  <= hold_next;
            gap_reg   <= gap_next;
            click_reg <= click_next;
            long_reg  <= long_next;
        end
    end

    // Saturating increments.
    assign hold_inc  = mckd_pkg::sat_inc(hold_reg);
    assign gap_inc   = mckd_pkg::sat_inc(gap_reg);
    assign click_inc = (click_reg == {CLICK_WIDTH{1'b1}}) ? click_reg : click_reg + 1'b1;

    // Next state and counters for this tick.
    always_comb begin
        mode_next  = mode_reg;
        hold_next  = hold_reg;
        gap_next   = gap_reg;
        click_next = click_reg;
        long_next  = long_reg;
        unique case (mode_reg)
            mckd_pkg::MODE_IDLE: begin
                if (pressed) begin
                    mode_next = mckd_pkg::MODE_DEBOUNCE;
                    hold_next = '0;
                end
            end
            mckd_pkg::MODE_DEBOUNCE: begin
                if (!pressed) begin
                    mode_next = mckd_pkg::MODE_IDLE;
                end else if (hold_inc >= cfg.debounce) begin
                    mode_next = mckd_pkg::MODE_HELD;
                    hold_next = '0;
                    long_next = 1'b0;
                end else begin
                    hold_next = hold_inc;
                end
            end
            mckd_pkg::MODE_HELD: begin
                if (pressed) begin
                    hold_next = hold_inc;
                    if (!long_reg && hold_inc >= cfg.long_press) begin
                        long_next = 1'b1;
                    end
                end else if (!long_reg) begin
                    click_next = click_inc;
                    gap_next   = '0;
                    mode_next  = mckd_pkg::MODE_GAP;
                end else begin
                    long_next = 1'b0;
                    mode_next = mckd_pkg::MODE_IDLE;
                end
            end
            mckd_pkg::MODE_GAP: begin
                gap_next = gap_inc;
                if (pressed) begin
                    hold_next = '0;
                    mode_next = mckd_pkg::MODE_DEBOUNCE;
                end else if (gap_inc >= cfg.click_window) begin
                    gap_next   = '0;
                    click_next = '0;
                    mode_next  = mckd_pkg::MODE_IDLE;
                end
            end
            default: begin
                mode_next = mckd_pkg::MODE_IDLE;
            end
        endcase
    end

    // The report shows the low bits of the click count after the update.
    assign report_next.clicks     = mckd_pkg::OUT_CLICK_WIDTH'(click_next);
    assign report_next.long_press = long_next;

    // The long-press flag is only ever set while the key is held.
    a_long_only_held: assert property (@(posedge aclk) disable iff (!aresetn)
        long_reg |-> mode_reg == mckd_pkg::MODE_HELD)
        else $error("long-press flag set outside the held mode");

    // Without an item the lane state does not move.
    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(mode_reg) && $stable(click_reg) && $stable(long_reg))
        else $error("lane state changed without an accepted item");

endmodule

[hdl/mckd_merge.sv]
// Merging stage: collects the lane reports into the result register and
// runs the result handshake. Depends on mckd_pkg.
module mckd_merge #(
    parameter int NUM_KEYS = mckd_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_accept,
    input  mckd_pkg::lane_report_t lane_report [NUM_KEYS],
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic                   take_ready,
    output mckd_pkg::lane_report_t out_report [mckd_pkg::OUT_KEYS]
);

    logic                   valid_reg;
    mckd_pkg::lane_report_t report_reg [mckd_pkg::OUT_KEYS];
    mckd_pkg::lane_report_t report_next [mckd_pkg::OUT_KEYS];

    // A new item may enter when the result register is empty or being taken.
    assign take_ready = !valid_reg || m_ready;

    // Keys beyond the lane count read as zero.
    always_comb begin
        for (int k = 0; k < mckd_pkg::OUT_KEYS; k++) begin
            report_next[k] = '0;
            if (k < NUM_KEYS) begin
                report_next[k] = lane_report[k];
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_accept) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            report_reg <= report_next;
        end
    end

    assign m_valid    = valid_reg;
    assign out_report = report_reg;

    // Every accepted item shows up as a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> valid_reg)
        else $error("accepted item produced no result");

endmodule

[hdl/multi_click_key_detector.sv]
// Top level of the multi-click key detector: configuration registers, one lane
// per key and the merging stage. Depends on mckd_pkg, mckd_lane, mckd_merge.
//
// Each item is one scan tick with the pressed levels of four keys; each
// result gives every key's click count and long-press flag after that tick.
// The block takes one item per clock: every lane updates its key state as the
// item is accepted, and the result appears in the output register in the cycle
// after that. While a result waits, s_ready follows m_ready, so a stalled
// result only holds off the next item for as long as it waits. Configuration
// writes are always taken (cfg_ready is tied high); index 3 is ignored.
module multi_click_key_detector #(
    parameter int NUM_KEYS    = mckd_pkg::NUM_KEYS_DEFAULT,
    parameter int CLICK_WIDTH = mckd_pkg::CLICK_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration port
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mckd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mckd_pkg::TICK_WIDTH-1:0]        cfg_data,
    // Input items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mckd_pkg::IN_KEYS-1:0]           s_pressed_keys,
    // Result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mckd_pkg::OUT_CLICK_WIDTH-1:0]   m_clicks_key0,
    output logic                                   m_long_key0,
    output logic [mckd_pkg::OUT_CLICK_WIDTH-1:0]   m_clicks_key1,
    output logic                                   m_long_key1,
    output logic [mckd_pkg::OUT_CLICK_WIDTH-1:0]   m_clicks_key2,
    output logic                                   m_long_key2,
    output logic [mckd_pkg::OUT_CLICK_WIDTH-1:0]   m_clicks_key3,
    output logic                                   m_long_key3
);

    mckd_pkg::cfg_t         cfg_reg;
    logic                   in_accept;
    logic                   take_ready;
    logic [NUM_KEYS-1:0]    lane_pressed;
    mckd_pkg::lane_report_t lane_report [NUM_KEYS];
    mckd_pkg::lane_report_t out_report  [mckd_pkg::OUT_KEYS];

    assign cfg_ready = 1'b1;
    assign s_ready   = take_ready;
    assign in_accept = s_valid && take_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce     <= mckd_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press   <= mckd_pkg::LONG_PRESS_RESET;
            cfg_reg.click_window <= mckd_pkg::CLICK_WINDOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mckd_pkg::REG_DEBOUNCE:     cfg_reg.debounce     <= cfg_data;
                mckd_pkg::REG_LONG_PRESS:   cfg_reg.long_press   <= cfg_data;
                mckd_pkg::REG_CLICK_WINDOW: cfg_reg.click_window <= cfg_data;
                default: ;
            endcase
        end
    end

    // Keys beyond the input field see a released key.
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            lane_pressed[k] = 1'b0;
            if (k < mckd_pkg::IN_KEYS) begin
                lane_pressed[k] = s_pressed_keys[k];
            end
        end
    end

    // One lane per key.
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        mckd_lane #(
            .CLICK_WIDTH (CLICK_WIDTH)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .advance     (in_accept),
            .pressed     (lane_pressed[g]),
            .cfg         (cfg_reg),
            .report_next (lane_report[g])
        );
    end

    // Result register and handshake.
    mckd_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .lane_report (lane_report),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .take_ready  (take_ready),
        .out_report  (out_report)
    );

    assign m_clicks_key0 = out_report[0].clicks;
    assign m_long_key0   = out_report[0].long_press;
    assign m_clicks_key1 = out_report[1].clicks;
    assign m_long_key1   = out_report[1].long_press;
    assign m_clicks_key2 = out_report[2].clicks;
    assign m_long_key2   = out_report[2].long_press;
    assign m_clicks_key3 = out_report[3].clicks;
    assign m_long_key3   = out_report[3].long_press;

    // A debounce write lands in its register.
    a_cfg_debounce_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index == mckd_pkg::REG_DEBOUNCE
        |=> cfg_reg.debounce == $past(cfg_data))
        else $error("debounce register write lost");

endmodule

[bench/mckd_scan_checker.sv]
// Scoreboard for the multi-click key detector: watches the register, scan
// and result channels, predicts every result and compares it field by field.
// Depends on mckd_pkg.
module mckd_scan_checker
    import mckd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [TICK_WIDTH-1:0]      cfg_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [IN_KEYS-1:0]         s_pressed_keys,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [OUT_CLICK_WIDTH-1:0] m_clicks_key0,
    input  logic                       m_long_key0,
    input  logic [OUT_CLICK_WIDTH-1:0] m_clicks_key1,
    input  logic                       m_long_key1,
    input  logic [OUT_CLICK_WIDTH-1:0] m_clicks_key2,
    input  logic                       m_long_key2,
    input  logic [OUT_CLICK_WIDTH-1:0] m_clicks_key3,
    input  logic                       m_long_key3,
    output int                         mismatches,
    output int                         outstanding
);

    typedef lane_report_t [OUT_KEYS-1:0] scan_report_t;

    // Shadow copy of the thresholds and of every key's state.
    cfg_t                       thresholds;
    key_mode_t                  key_mode    [OUT_KEYS];
    logic [TICK_WIDTH-1:0]      hold_ticks  [OUT_KEYS];
    logic [TICK_WIDTH-1:0]      gap_ticks   [OUT_KEYS];
    logic [OUT_CLICK_WIDTH-1:0] click_total [OUT_KEYS];
    logic                       long_held   [OUT_KEYS];

    // Key reports still owed by the block, oldest first.
    scan_report_t               pending_reports [$];
    int                         error_count = 0;

    // Advances every key by one scan tick and returns what the block should report.
    function automatic scan_report_t scan_keys(input logic [IN_KEYS-1:0] pressed);
        scan_report_t report;
        logic         p;
        for (int k = 0; k < OUT_KEYS; k++) begin
            p = pressed[k];
            case (key_mode[k])
                MODE_IDLE: begin
                    if (p) begin
                        key_mode[k]   = MODE_DEBOUNCE;
                        hold_ticks[k] = '0;
                    end
                end
                MODE_DEBOUNCE: begin
                    if (!p) begin
                        key_mode[k] = MODE_IDLE;
                    end else begin
                        if (hold_ticks[k] != '1)
                            hold_ticks[k] = hold_ticks[k] + 1'b1;
                        if (hold_ticks[k] >= thresholds.debounce) begin
                            key_mode[k]   = MODE_HELD;
                            hold_ticks[k] = '0;
                            long_held[k]  = 1'b0;
                        end
                    end
                end
                MODE_HELD: begin
                    if (p) begin
                        if (hold_ticks[k] != '1)
                            hold_ticks[k] = hold_ticks[k] + 1'b1;
                        if (!long_held[k] && hold_ticks[k] >= thresholds.long_press)
                            long_held[k] = 1'b1;
                    end else if (!long_held[k]) begin
                        // A short press ends: count the click and open the window.
                        if (click_total[k] != '1)
                            click_total[k] = click_total[k] + 1'b1;
                        gap_ticks[k] = '0;
                        key_mode[k]  = MODE_GAP;
                    end else begin
                        // A long press ends without a click; the count is kept.
                        long_held[k] = 1'b0;
                        key_mode[k]  = MODE_IDLE;
                    end
                end
                default: begin
                    if (gap_ticks[k] != '1)
                        gap_ticks[k] = gap_ticks[k] + 1'b1;
                    if (p) begin
                        hold_ticks[k] = '0;
                        key_mode[k]   = MODE_DEBOUNCE;
                    end else if (gap_ticks[k] >= thresholds.click_window) begin
                        gap_ticks[k]   = '0;
                        click_total[k] = '0;
                        key_mode[k]    = MODE_IDLE;
                    end
                end
            endcase
            report[k].clicks     = click_total[k];
            report[k].long_press = long_held[k];
        end
        return report;
    endfunction

    // Compares one result with the report that was expected for it.
    function automatic void compare_report(input scan_report_t want, input scan_report_t got);
        for (int k = 0; k < OUT_KEYS; k++) begin
            if (got[k].clicks !== want[k].clicks) begin
                error_count++;
                $display("%0t: key %0d click count expected %0d, got %0d",
                         $time, k, want[k].clicks, got[k].clicks);
            end
            if (got[k].long_press !== want[k].long_press) begin
                error_count++;
                $display("%0t: key %0d long-press flag expected %0b, got %0b",
                         $time, k, want[k].long_press, got[k].long_press);
            end
        end
    endfunction

    // Everything is sampled at the rising edge, before the block's registers move.
    always @(posedge aclk) begin : watch
        scan_report_t got;
        if (!aresetn) begin
            thresholds.debounce     = DEBOUNCE_RESET;
            thresholds.long_press   = LONG_PRESS_RESET;
            thresholds.click_window = CLICK_WINDOW_RESET;
            for (int k = 0; k < OUT_KEYS; k++) begin
                key_mode[k]    = MODE_IDLE;
                hold_ticks[k]  = '0;
                gap_ticks[k]   = '0;
                click_total[k] = '0;
                long_held[k]   = 1'b0;
            end
            pending_reports.delete();
        end else begin
            // Register writes; the spare index is ignored.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE:     thresholds.debounce     = cfg_data;
                    REG_LONG_PRESS:   thresholds.long_press   = cfg_data;
                    REG_CLICK_WINDOW: thresholds.click_window = cfg_data;
                    default: ;
                endcase
            end
            // Results are taken before new items so that an early result is caught.
            if (m_valid && m_ready) begin
                got[0].clicks = m_clicks_key0;
                got[0].long_press = m_long_key0;
                got[1].clicks = m_clicks_key1;
                got[1].long_press = m_long_key1;
                got[2].clicks = m_clicks_key2;
                got[2].long_press = m_long_key2;
                got[3].clicks = m_clicks_key3;
                got[3].long_press = m_long_key3;
                if (pending_reports.size() == 0) begin
                    error_count++;
                    $display("%0t: result expected none, got clicks %0d/%0d/%0d/%0d",
                             $time, got[0].clicks, got[1].clicks, got[2].clicks,
                             got[3].clicks);
                end else begin
                    compare_report(pending_reports.pop_front(), got);
                end
            end
            if (s_valid && s_ready)
                pending_reports.push_back(scan_keys(s_pressed_keys));
        end
        mismatches  <= error_count;
        outstanding <= pending_reports.size();
    end

endmodule

[bench/multi_click_key_detector_tb.sv]
// Testbench top for the multi-click key detector: clock, reset, register
// programming and scan stimulus, with random stalls on both channels.
// Depends on mckd_pkg, multi_click_key_detector and mckd_scan_checker.
module multi_click_key_detector_tb;
    import mckd_pkg::*;

    // The one index on the register port that has no register behind it.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_TICKS = 4;

    // Directed scans, first nibble first: at the reset thresholds, then at zero.
    localparam logic [47:0] EARLY_SCANS = 48'h0FFF_055A_AF00;
    localparam logic [47:0] ZERO_SCANS  = 48'hFF00_F0FF_F03C;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [TICK_WIDTH-1:0]      cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [IN_KEYS-1:0]         s_pressed_keys;
    logic                       m_valid;
    logic                       m_ready;
    logic [OUT_CLICK_WIDTH-1:0] m_clicks_key0, m_clicks_key1, m_clicks_key2, m_clicks_key3;
    logic                       m_long_key0, m_long_key1, m_long_key2, m_long_key3;

    int mismatches;
    int outstanding;

    // Stimulus state: the thresholds in force and each key's press pattern.
    int   cur_debounce = DEBOUNCE_RESET;
    int   cur_long     = LONG_PRESS_RESET;
    int   cur_window   = CLICK_WINDOW_RESET;
    bit   calm         = 1'b0;
    int   ticks_sent   = 0;
    int   settings_used = 1;
    int   key_run    [IN_KEYS];
    logic key_down   [IN_KEYS];
    int   key_streak [IN_KEYS];

    multi_click_key_detector dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pressed_keys (s_pressed_keys),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_clicks_key0  (m_clicks_key0),
        .m_long_key0    (m_long_key0),
        .m_clicks_key1  (m_clicks_key1),
        .m_long_key1    (m_long_key1),
        .m_clicks_key2  (m_clicks_key2),
        .m_long_key2    (m_long_key2),
        .m_clicks_key3  (m_clicks_key3),
        .m_long_key3    (m_long_key3)
    );

    mckd_scan_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pressed_keys (s_pressed_keys),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_clicks_key0  (m_clicks_key0),
        .m_long_key0    (m_long_key0),
        .m_clicks_key1  (m_clicks_key1),
        .m_long_key1    (m_long_key1),
        .m_clicks_key2  (m_clicks_key2),
        .m_long_key2    (m_long_key2),
        .m_clicks_key3  (m_clicks_key3),
        .m_long_key3    (m_long_key3),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog.
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall bursts, none once the run has gone calm.
    initial begin : result_sink
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // Offers one scan item and holds it until the block takes it.
    task automatic send_scan(input logic [IN_KEYS-1:0] bits);
        s_valid        <= 1'b1;
        s_pressed_keys <= bits;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // Lowers the scan valid and waits until every result is in, plus a margin.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Writes all three thresholds and the spare index in one burst.
    task automatic program_thresholds(input int debounce, input int long_press, input int window);
        logic [CFG_INDEX_WIDTH-1:0] idx [4];
        logic [TICK_WIDTH-1:0]      val [4];
        idx[0] = REG_DEBOUNCE;     val[0] = debounce[TICK_WIDTH-1:0];
        idx[1] = REG_LONG_PRESS;   val[1] = long_press[TICK_WIDTH-1:0];
        idx[2] = REG_CLICK_WINDOW; val[2] = window[TICK_WIDTH-1:0];
        idx[3] = REG_SPARE;        val[3] = TICK_WIDTH'($urandom_range(0, 255));
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid    <= 1'b0;
        cur_debounce = debounce;
        cur_long     = long_press;
        cur_window   = window;
        settings_used++;
    endtask

    // Builds the next scan from per-key runs of press and release, sized
    // against the current thresholds so that bounces, clicks, long presses,
    // click chains and expired windows all occur; some scans are pure noise.
    function automatic logic [IN_KEYS-1:0] next_scan();
        logic [IN_KEYS-1:0] bits;
        int                 c;
        for (int k = 0; k < IN_KEYS; k++) begin
            if (key_run[k] == 0) begin
                key_down[k] = !key_down[k];
                c = $urandom_range(0, 29);
                if (key_down[k]) begin
                    if (c < 6)
                        key_run[k] = $urandom_range(1, (cur_debounce > 0) ? cur_debounce : 1);
                    else if (c < 18)
                        key_run[k] = cur_debounce + $urandom_range(1, (cur_long > 0) ? cur_long : 1);
                    else if (c < 29)
                        key_run[k] = cur_debounce + cur_long + $urandom_range(1, 8);
                    else
                        key_run[k] = cur_debounce + 260;
                end else if (key_streak[k] > 0 || c < 20) begin
                    if (key_streak[k] > 0)
                        key_streak[k]--;
                    key_run[k] = $urandom_range(1, (cur_window > 0) ? cur_window : 1);
                end else begin
                    key_run[k] = cur_window + $urandom_range(1, 6);
                    // Now and then the next chain runs long enough to saturate.
                    if ($urandom_range(0, 3) == 0)
                        key_streak[k] = 18;
                end
            end
            key_run[k]--;
            bits[k] = key_down[k];
        end
        if ($urandom_range(0, 15) == 0)
            bits = IN_KEYS'($urandom_range(0, 15));
        return bits;
    endfunction

    // Main stimulus.
    initial begin : stimulus
        int debounce, long_press, window, count;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_pressed_keys <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_DEBOUNCE;
        cfg_data       <= '0;
        for (int k = 0; k < IN_KEYS; k++) begin
            key_run[k]    = 0;
            key_down[k]   = 1'b0;
            key_streak[k] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset thresholds, then all thresholds at zero.
        for (int i = 11; i >= 0; i--)
            send_scan(EARLY_SCANS[4*i +: 4]);
        settle();
        program_thresholds(0, 0, 0);
        for (int i = 11; i >= 0; i--)
            send_scan(ZERO_SCANS[4*i +: 4]);
        settle();

        // Random phases over several threshold settings.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    debounce = DEBOUNCE_RESET; long_press = LONG_PRESS_RESET;
                    window = CLICK_WINDOW_RESET; count = 300;
                end
                1: begin
                    debounce = 1; long_press = 1; window = 1; count = 200;
                end
                2: begin
                    debounce = 0; long_press = 0; window = 0; count = 150;
                end
                4: begin
                    debounce = 255; long_press = 255; window = 255; count = 400;
                end
                default: begin
                    debounce   = $urandom_range(1, 4);
                    long_press = $urandom_range(2, 12);
                    window     = $urandom_range(2, 10);
                    count      = 250;
                end
            endcase
            // The last phase runs without any idling on either side.
            if (phase == 5)
                calm = 1'b1;
            program_thresholds(debounce, long_press, window);
            for (int n = 0; n < count; n++) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge aclk);
                end
                send_scan(next_scan());
            end
            settle();
        end

        $display("Ran %0d scan ticks under %0d threshold settings, zero and full scale among them,",
                 ticks_sent, settings_used);
        $display("with random stalls on the scan and result channels.");
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
